>>> src/c2dbg_pkg.sv
// Shared types and constants for the two-wire debug frame master.
// No dependencies; imported by every module under src.
package c2dbg_pkg;

	localparam int MAX_DATA_BYTES_DEF = 4;

	localparam logic [1:0] OP_AW = 2'd0;
	localparam logic [1:0] OP_AR = 2'd1;
	localparam logic [1:0] OP_DW = 2'd2;
	localparam logic [1:0] OP_DR = 2'd3;

	localparam logic [1:0] REG_CODE_AW = 2'd0;
	localparam logic [1:0] REG_CODE_AR = 2'd1;
	localparam logic [1:0] REG_CODE_DW = 2'd2;
	localparam logic [1:0] REG_CODE_DR = 2'd3;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_START = 8'b0000_0010,
		PH_INSTR = 8'b0000_0100,
		PH_LEN   = 8'b0000_1000,
		PH_WRITE = 8'b0001_0000,
		PH_TURN  = 8'b0010_0000,
		PH_POLL  = 8'b0100_0000,
		PH_READ  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] aw;
		logic [1:0] ar;
		logic [1:0] dw;
		logic [1:0] dr;
	} codes_t;

	typedef struct packed {
		logic        action;
		logic [1:0]  operation;
		logic [2:0]  byte_count;
		logic [31:0] write_value;
		logic        data_pin_sample;
	} item_t;

	typedef struct packed {
		logic        clock_pulse;
		logic        data_drive_enable;
		logic        data_drive_level;
		logic        busy_res;
		logic        done_res;
		logic [31:0] read_value;
	} result_t;

endpackage

>>> src/two_wire_debug_frame_master.sv
// Top level of the two-wire debug frame master: input register, frame core,
// result register and code registers. Depends on c2dbg_pkg and submodules.
//
//   channel | direction | payload
//   s_*     | in        | one start or tick item (tuser = action)
//   m_*     | out       | one pulse slot result (tlast = done)
//   cfg_*   | in        | instruction code register writes
//
// One item per cycle unless the m side stalls; input then result register.
// The phase state updates as an item moves into the result register.
// A stalled m side holds one result and one item in the input register.
// Reset puts the frame in idle and restores the default instruction codes.
module two_wire_debug_frame_master
	import c2dbg_pkg::*;
#(
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] operation, [4:2] byte_count, [36:5] write_value,
	// [37] data_pin_sample, [39:38] zero
	input  logic [39:0] s_tdata,
	// [0] action
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] clock_pulse, [1] data_drive_enable, [2] data_drive_level,
	// [3] busy_res, [35:4] read_value, [39:36] zero
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	logic    s1_valid_q;
	item_t   item_s1;
	logic    m_valid_q;
	result_t res_q;
	result_t res_d;
	codes_t  codes;
	logic    advance;
	logic    s_accept;

	assign advance  = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s_accept)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;
			if (advance)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.action          <= s_tuser;
			item_s1.operation       <= s_tdata[1:0];
			item_s1.byte_count      <= s_tdata[4:2];
			item_s1.write_value     <= s_tdata[36:5];
			item_s1.data_pin_sample <= s_tdata[37];
		end
		if (advance)
			res_q <= res_d;
	end

	c2dbg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	c2dbg_frame_core #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.codes   (codes),
		.res     (res_d)
	);

	assign m_tvalid = m_valid_q;
	assign m_tlast  = res_q.done_res;
	assign m_tdata  = {4'b0000, res_q.read_value, res_q.busy_res,
		res_q.data_drive_level, res_q.data_drive_enable, res_q.clock_pulse};

endmodule

>>> src/c2dbg_cfg_regs.sv
// Instruction code registers written through the plain configuration port.
// Depends on c2dbg_pkg.
module c2dbg_cfg_regs
	import c2dbg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data,
	output codes_t     codes
);

	codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.aw <= 2'd3;
			codes_q.ar <= 2'd2;
			codes_q.dw <= 2'd1;
			codes_q.dr <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CODE_AW: codes_q.aw <= cfg_data;
				REG_CODE_AR: codes_q.ar <= cfg_data;
				REG_CODE_DW: codes_q.dw <= cfg_data;
				REG_CODE_DR: codes_q.dr <= cfg_data;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

>>> src/c2dbg_frame_core.sv
// Frame sequencer: phase state, bit counter and shift registers; forms one
// result per item as it advances. Depends on c2dbg_pkg.
module c2dbg_frame_core
	import c2dbg_pkg::*;
#(
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  codes_t  codes,
	output result_t res
);

	localparam logic [2:0] MaxCnt = 3'(MAX_DATA_BYTES);

	phase_t      phase_q, phase_d;
	logic [5:0]  bit_cnt_q, bit_cnt_d;
	logic [31:0] tx_q, tx_d;
	logic [31:0] rx_q, rx_d;
	logic [1:0]  op_q, op_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [1:0]  code_sel;
	logic [2:0]  len_m1;
	logic [5:0]  total_bits;
	logic [5:0]  bit_inc;
	logic [2:0]  cnt_in;

	assign len_m1     = cnt_q - 3'd1;
	assign total_bits = {cnt_q, 3'b000};
	assign bit_inc    = bit_cnt_q + 6'd1;

	always_comb begin
		case (op_q)
			OP_AW:   code_sel = codes.aw;
			OP_AR:   code_sel = codes.ar;
			OP_DW:   code_sel = codes.dw;
			default: code_sel = codes.dr;
		endcase
	end

	always_comb begin
		cnt_in = item.byte_count;
		if (item.operation == OP_AW || item.operation == OP_AR)
			cnt_in = 3'd1;
		if (cnt_in == 3'd0)
			cnt_in = 3'd1;
		if (cnt_in > MaxCnt)
			cnt_in = MaxCnt;
	end

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		tx_d      = tx_q;
		rx_d      = rx_q;
		op_d      = op_q;
		cnt_d     = cnt_q;
		res       = '0;
		if (item.action) begin
			op_d         = item.operation;
			cnt_d        = cnt_in;
			tx_d         = item.write_value;
			rx_d         = '0;
			bit_cnt_d    = '0;
			phase_d      = PH_START;
			res.busy_res = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			res.clock_pulse = 1'b1;
			res.busy_res    = 1'b1;
			case (phase_q)
				PH_START: begin
					bit_cnt_d = '0;
					phase_d   = PH_INSTR;
				end
				PH_INSTR: begin
					res.data_drive_enable = 1'b1;
					res.data_drive_level  = code_sel[bit_cnt_q[0]];
					bit_cnt_d             = bit_inc;
					if (bit_inc >= 6'd2) begin
						bit_cnt_d = '0;
						if (op_q == OP_DW || op_q == OP_DR)
							phase_d = PH_LEN;
						else if (op_q == OP_AW)
							phase_d = PH_WRITE;
						else
							phase_d = PH_TURN;
					end
				end
				PH_LEN: begin
					res.data_drive_enable = 1'b1;
					res.data_drive_level  = len_m1[bit_cnt_q[0]];
					bit_cnt_d             = bit_inc;
					if (bit_inc >= 6'd2) begin
						bit_cnt_d = '0;
						phase_d   = (op_q == OP_DW) ? PH_WRITE : PH_TURN;
					end
				end
				PH_WRITE: begin
					res.data_drive_enable = 1'b1;
					res.data_drive_level  = tx_q[0];
					tx_d                  = {1'b0, tx_q[31:1]};
					bit_cnt_d             = bit_inc;
					if (bit_inc >= total_bits) begin
						bit_cnt_d = '0;
						phase_d   = PH_TURN;
					end
				end
				PH_TURN: begin
					bit_cnt_d = '0;
					if (op_q == OP_AW) begin
						phase_d        = PH_IDLE;
						res.busy_res   = 1'b0;
						res.done_res   = 1'b1;
						res.read_value = rx_q;
					end else if (op_q == OP_AR) begin
						phase_d = PH_READ;
					end else begin
						phase_d = PH_POLL;
					end
				end
				PH_POLL: begin
					if (item.data_pin_sample) begin
						bit_cnt_d = '0;
						if (op_q == OP_DW) begin
							phase_d        = PH_IDLE;
							res.busy_res   = 1'b0;
							res.done_res   = 1'b1;
							res.read_value = rx_q;
						end else begin
							phase_d = PH_READ;
						end
					end
				end
				PH_READ: begin
					if (item.data_pin_sample)
						rx_d[bit_cnt_q[4:0]] = 1'b1;
					bit_cnt_d = bit_inc;
					if (bit_inc >= total_bits) begin
						bit_cnt_d      = '0;
						phase_d        = PH_IDLE;
						res.busy_res   = 1'b0;
						res.done_res   = 1'b1;
						res.read_value = rx_d;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			tx_q      <= '0;
			rx_q      <= '0;
			op_q      <= OP_AW;
			cnt_q     <= 3'd1;
		end else if (advance) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			tx_q      <= tx_d;
			rx_q      <= rx_d;
			op_q      <= op_d;
			cnt_q     <= cnt_d;
		end
	end

endmodule
